// ===== rtl/ims_pkg.sv =====
// Package for the I2C master bit sequencer.
// Holds command codes, wait kinds, register indexes and the sequencer state type.
// No dependencies.
package ims_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int TICK_W     = 16;
    localparam int PHASE_W    = 5;
    localparam int BITCNT_W   = 4;
    localparam int BYTE_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = CFG_IDX_W'(1);

    localparam logic [TICK_W-1:0] SHORT_TICKS_RST = TICK_W'(100);
    localparam logic [TICK_W-1:0] LONG_TICKS_RST  = TICK_W'(1000);

    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = BITCNT_W'(8);

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_CHECK = 3'd5,
        CMD_ACK   = 3'd6,
        CMD_NACK  = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        WAIT_NONE  = 2'd0,
        WAIT_SHORT = 2'd1,
        WAIT_LONG  = 2'd2
    } wait_kind_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [PHASE_W-1:0]    phase;
        logic [TICK_W-1:0]     wait_cnt;
        logic [BYTE_W-1:0]     shift;
        logic [BITCNT_W-1:0]   bit_cnt;
        logic                  scl;
        logic                  sda;
        logic                  dir;
        logic                  ack;
        logic [BYTE_W-1:0]     held_read;
    } seq_state_t;

    // idle, both lines high, SDA driven
    localparam seq_state_t SEQ_STATE_RST = '{
        cmd:       CMD_NONE,
        phase:     '0,
        wait_cnt:  '0,
        shift:     '0,
        bit_cnt:   '0,
        scl:       1'b1,
        sda:       1'b1,
        dir:       1'b1,
        ack:       1'b0,
        held_read: '0
    };

endpackage

// ===== rtl/ims_if.sv =====
// Handshake interfaces for the I2C master bit sequencer: tick words in,
// result words out, configuration writes. Depends on ims_pkg.
interface ims_in_if;
    import ims_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [BYTE_W-1:0]  write_byte;
    logic               sda_level;
    modport source (output valid, op, write_byte, sda_level, input ready);
    modport sink   (input valid, op, write_byte, sda_level, output ready);
endinterface

interface ims_out_if;
    import ims_pkg::*;
    logic               valid;
    logic               ready;
    logic               scl_level;
    logic               sda_drive;
    logic               sda_output_enable;
    logic               busy_res;
    logic               done_res;
    logic [BYTE_W-1:0]  read_data;
    logic               ack_seen;
    modport source (output valid, scl_level, sda_drive, sda_output_enable, busy_res,
                    done_res, read_data, ack_seen, input ready);
    modport sink   (input valid, scl_level, sda_drive, sda_output_enable, busy_res,
                    done_res, read_data, ack_seen, output ready);
endinterface

interface ims_cfg_if;
    import ims_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [TICK_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/i2c_master_bit_sequencer_top.sv =====
// A result word appears in the cycle after its tick word is accepted.
// One tick word per cycle unless a result word stalls; next-state logic is
// a single pass between sequencer state registers and the result register.
// Reset (rst_n low, asynchronous): no command, SCL and SDA high, SDA driven,
// wait lengths 100 and 1000 ticks, result register empty.
module i2c_master_bit_sequencer_top (
    input  logic  clk,
    input  logic  rst_n,
    ims_in_if.sink    req,
    ims_out_if.source rsp,
    ims_cfg_if.sink   cfg
);
    import ims_pkg::*;

    seq_state_t           state_reg;
    seq_state_t           state_next;
    logic                 done_next;
    logic [TICK_W-1:0]    short_ticks_reg;
    logic [TICK_W-1:0]    long_ticks_reg;
    logic                 rsp_valid_reg;
    logic                 accept;

    ims_step u_step (
        .cur         (state_reg),
        .op          (req.op),
        .write_byte  (req.write_byte),
        .sda_level   (req.sda_level),
        .short_ticks (short_ticks_reg),
        .long_ticks  (long_ticks_reg),
        .nxt         (state_next),
        .done        (done_next)
    );

    assign req.ready = ~rsp_valid_reg | rsp.ready;
    assign accept    = req.valid & req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_ticks_reg <= SHORT_TICKS_RST;
            long_ticks_reg  <= LONG_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_SHORT_TICKS)
                short_ticks_reg <= cfg.data;
            else if (cfg.index == REG_LONG_TICKS)
                long_ticks_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_STATE_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // result word; payload only, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp.scl_level         <= state_next.scl;
            rsp.sda_drive         <= state_next.sda;
            rsp.sda_output_enable <= state_next.dir;
            rsp.busy_res          <= (state_next.cmd != CMD_NONE);
            rsp.done_res          <= done_next;
            rsp.read_data         <= state_next.held_read;
            rsp.ack_seen          <= state_next.ack;
        end
    end

endmodule

// ===== rtl/ims_step.sv =====
// Next-state logic of the I2C master bit sequencer for one tick.
// Runs the pin actions of the active command up to its next wait.
// Depends on ims_pkg.
module ims_step (
    input  ims_pkg::seq_state_t        cur,
    input  logic [2:0]                 op,
    input  logic [ims_pkg::BYTE_W-1:0] write_byte,
    input  logic                       sda_level,
    input  logic [ims_pkg::TICK_W-1:0] short_ticks,
    input  logic [ims_pkg::TICK_W-1:0] long_ticks,
    output ims_pkg::seq_state_t        nxt,
    output logic                       done
);
    import ims_pkg::*;

    always_comb
    begin
        logic                 run;
        logic [PHASE_W-1:0]   p;
        logic [TICK_W-1:0]    cnt;
        logic [TICK_W-1:0]    len;
        wait_kind_t           kind;

        nxt  = cur;
        run  = 1'b0;
        kind = WAIT_NONE;
        cnt  = cur.wait_cnt;
        len  = short_ticks;
        p    = cur.phase;
        done = 1'b0;

        if (cur.cmd == CMD_NONE)
        begin
            if (op != CMD_NONE)
            begin
                nxt.cmd   = cmd_t'(op);
                nxt.phase = '0;
                if (cmd_t'(op) == CMD_WRITE)
                    nxt.shift = write_byte;
                run = 1'b1;
            end
        end
        else
        begin
            if (cnt != '0)
                cnt = cnt - TICK_W'(1);
            nxt.wait_cnt = cnt;
            if (cnt == '0)
                run = 1'b1;
        end

        if (run)
        begin
            p         = nxt.phase;
            nxt.phase = p + PHASE_W'(1);
            unique case (nxt.cmd)
                CMD_START:
                begin
                    if (p == PHASE_W'(0))
                    begin
                        nxt.sda = 1'b1; nxt.scl = 1'b1; kind = WAIT_LONG;
                    end
                    else if (p == PHASE_W'(1))
                    begin
                        nxt.sda = 1'b0; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(2))
                    begin
                        nxt.scl = 1'b0; kind = WAIT_SHORT;
                    end
                end
                CMD_STOP:
                begin
                    if (p == PHASE_W'(0))
                    begin
                        nxt.dir = 1'b1; nxt.sda = 1'b0; nxt.scl = 1'b0; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(1))
                    begin
                        nxt.scl = 1'b1; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(2))
                    begin
                        nxt.sda = 1'b1; kind = WAIT_SHORT;
                    end
                end
                CMD_WRITE:
                begin
                    if (p == PHASE_W'(0))
                    begin
                        nxt.dir = 1'b1; nxt.bit_cnt = '0; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(1))
                    begin
                        nxt.sda = nxt.shift[BYTE_W-1]; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(2))
                    begin
                        nxt.scl = 1'b1; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(3))
                    begin
                        nxt.scl = 1'b0; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(4))
                    begin
                        nxt.shift   = {nxt.shift[BYTE_W-2:0], 1'b0};
                        nxt.bit_cnt = nxt.bit_cnt + BITCNT_W'(1);
                        if (nxt.bit_cnt < BITS_PER_BYTE)
                        begin
                            // next bit goes straight onto SDA
                            nxt.phase = PHASE_W'(2);
                            nxt.sda   = nxt.shift[BYTE_W-1];
                            kind      = WAIT_SHORT;
                        end
                        else
                            nxt.sda = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (p == PHASE_W'(0))
                    begin
                        nxt.scl = 1'b0; nxt.sda = 1'b1; nxt.dir = 1'b0;
                        nxt.bit_cnt = '0; nxt.shift = '0;
                        kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(1))
                    begin
                        nxt.scl = 1'b1; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(2))
                    begin
                        nxt.shift   = {nxt.shift[BYTE_W-2:0], sda_level};
                        nxt.scl     = 1'b0;
                        nxt.bit_cnt = nxt.bit_cnt + BITCNT_W'(1);
                        if (nxt.bit_cnt < BITS_PER_BYTE)
                        begin
                            nxt.phase = PHASE_W'(1);
                            kind      = WAIT_SHORT;
                        end
                        else
                        begin
                            nxt.dir       = 1'b1;
                            nxt.held_read = nxt.shift;
                        end
                    end
                end
                CMD_CHECK:
                begin
                    if (p == PHASE_W'(0))
                    begin
                        nxt.sda = 1'b1; nxt.dir = 1'b0; kind = WAIT_LONG;
                    end
                    else if (p == PHASE_W'(1))
                    begin
                        nxt.scl = 1'b1; kind = WAIT_LONG;
                    end
                    else if (p == PHASE_W'(2))
                    begin
                        nxt.ack = ~sda_level; nxt.scl = 1'b0; kind = WAIT_SHORT;
                    end
                    else
                    begin
                        nxt.dir = 1'b1; nxt.sda = 1'b1;
                    end
                end
                CMD_ACK:
                begin
                    if (p == PHASE_W'(0))
                    begin
                        nxt.dir = 1'b1; nxt.sda = 1'b0; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(1))
                    begin
                        nxt.scl = 1'b1; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(2))
                    begin
                        nxt.scl = 1'b0; nxt.sda = 1'b1; nxt.dir = 1'b0; kind = WAIT_SHORT;
                    end
                end
                CMD_NACK:
                begin
                    if (p == PHASE_W'(0))
                    begin
                        nxt.dir = 1'b1; nxt.sda = 1'b1; nxt.scl = 1'b1; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(1))
                    begin
                        nxt.scl = 1'b0; kind = WAIT_SHORT;
                    end
                    else if (p == PHASE_W'(2))
                    begin
                        nxt.sda = 1'b1; kind = WAIT_SHORT;
                    end
                    else
                        nxt.dir = 1'b0;
                end
                default:
                    kind = WAIT_NONE;
            endcase

            if (kind == WAIT_LONG)
                len = long_ticks;
            if (kind == WAIT_NONE)
            begin
                done         = 1'b1;
                nxt.cmd      = CMD_NONE;
                nxt.phase    = '0;
                nxt.wait_cnt = '0;
            end
            else
                nxt.wait_cnt = (len == '0) ? TICK_W'(1) : len;
        end
    end

endmodule

// ===== rtl/ims_checker.sv =====
// Port-level checker for the I2C master bit sequencer, bound to the top level.
// Depends on ims_pkg and i2c_master_bit_sequencer_top.
module ims_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  logic                       rsp_busy,
    input  logic                       rsp_done,
    input  logic [ims_pkg::BYTE_W-1:0] rsp_read_data
);
    import ims_pkg::*;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_done |-> !rsp_busy)
        else $error("done word still shows busy");

    a_word_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready))
        else $error("result word without an accepted tick");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("tick stalled with empty result register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_done))
        else $error("stalled result word changed");

endmodule

bind i2c_master_bit_sequencer_top ims_checker u_ims_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_busy      (rsp.busy_res),
    .rsp_done      (rsp.done_res),
    .rsp_read_data (rsp.read_data)
);

// ===== tb/tb_i2c_master_bit_sequencer_top.sv =====
// Testbench for i2c_master_bit_sequencer_top: directed table, then random I2C transfers,
// every result word compared with a local bit-level model or a typed table row.
// Depends on ims_pkg and the ims_in_if / ims_out_if / ims_cfg_if interfaces.
module tb_i2c_master_bit_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ims_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int MAX_GAP       = 19;
    localparam int RANDOM_ITEMS  = 400;
    localparam int STALL_CYCLES  = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int FULL_SCALE_TICKS = 8;
    localparam longint RUN_LIMIT_NS = 64'd2_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

    typedef struct packed {
        logic             scl;
        logic             sda;
        logic             oe;
        logic             busy;
        logic             done;
        logic [BYTE_W-1:0] rd;
        logic             ack;
    } line_state_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        cmd_t                 op;
        logic [BYTE_W-1:0]    wb;
        logic                 sda;
        logic                 run_out;
        logic                 typed;
        line_state_t          want;
        logic [CFG_IDX_W-1:0] idx;
        logic [TICK_W-1:0]    val;
    } dir_row_t;

    typedef struct packed {
        logic [TICK_W-1:0] s_ticks;
        logic [TICK_W-1:0] l_ticks;
        logic              gaps;
        logic              pause;
        logic              stall;
    } phase_t;

    localparam line_state_t NO_WANT = '0;
    localparam line_state_t IDLE_AT_RESET =
        '{scl: 1'b1, sda: 1'b1, oe: 1'b1, busy: 1'b0, done: 1'b0, rd: 8'h00, ack: 1'b0};
    localparam line_state_t IDLE_READ_ONES =
        '{scl: 1'b0, sda: 1'b1, oe: 1'b1, busy: 1'b0, done: 1'b0, rd: 8'hFF, ack: 1'b0};
    localparam line_state_t IDLE_ACKED =
        '{scl: 1'b0, sda: 1'b1, oe: 1'b1, busy: 1'b0, done: 1'b0, rd: 8'h00, ack: 1'b1};

    // commands repeat while busy, so run_out rows also exercise the ignore path
    localparam dir_row_t DIRECTED [18] = '{
        '{ROW_TICK, CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b1, IDLE_AT_RESET,  '0, '0},
        '{ROW_CFG,  CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT, REG_SHORT_TICKS, 16'h0000},
        '{ROW_CFG,  CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT, REG_LONG_TICKS,  16'h0000},
        '{ROW_CFG,  CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT, REG_UNUSED,      16'hFFFF},
        '{ROW_TICK, CMD_START, 8'h00, 1'b1, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_WRITE, 8'hFF, 1'b0, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_WRITE, 8'h00, 1'b1, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_READ,  8'h00, 1'b1, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b1, IDLE_READ_ONES, '0, '0},
        '{ROW_TICK, CMD_READ,  8'hFF, 1'b0, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_CHECK, 8'h00, 1'b0, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b1, IDLE_ACKED,     '0, '0},
        '{ROW_TICK, CMD_CHECK, 8'h00, 1'b1, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_ACK,   8'h00, 1'b0, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_NACK,  8'h00, 1'b1, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_STOP,  8'h00, 1'b0, 1'b1, 1'b0, NO_WANT,        '0, '0},
        '{ROW_TICK, CMD_NONE,  8'hA5, 1'b1, 1'b0, 1'b1, IDLE_AT_RESET,  '0, '0},
        '{ROW_TICK, CMD_START, 8'h55, 1'b0, 1'b1, 1'b0, NO_WANT,        '0, '0}
    };

    localparam phase_t PHASES [4] = '{
        '{16'd1, 16'd1, 1'b1, 1'b0, 1'b0},
        '{16'd2, 16'd1, 1'b1, 1'b1, 1'b0},
        '{16'd1, 16'd4, 1'b0, 1'b0, 1'b1},
        '{16'd3, 16'd2, 1'b1, 1'b0, 1'b0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ims_in_if  req_if ();
    ims_out_if rsp_if ();
    ims_cfg_if cfg_if ();

    i2c_master_bit_sequencer_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // sequencer model state
    cmd_t               run_cmd    = CMD_NONE;
    logic [PHASE_W-1:0] step_no    = '0;
    logic [TICK_W-1:0]  ticks_left = '0;
    logic [BYTE_W-1:0]  shifter    = '0;
    logic [BITCNT_W-1:0] bits_done = '0;
    logic               scl_q      = 1'b1;
    logic               sda_q      = 1'b1;
    logic               oe_q       = 1'b1;
    logic               ack_q      = 1'b0;
    logic [BYTE_W-1:0]  rd_q       = '0;
    logic [TICK_W-1:0]  t_short    = SHORT_TICKS_RST;
    logic [TICK_W-1:0]  t_long     = LONG_TICKS_RST;

    line_state_t pending [$];
    cmd_t        bus_plan [$];

    bit gaps_on    = 1'b1;
    bit long_stall = 1'b0;
    bit req_up     = 1'b0;
    bit cfg_up     = 1'b0;
    int errors     = 0;
    int ticks_sent = 0;
    int work_items = 0;
    int cmds_done  = 0;
    int checked    = 0;

    always #CLK_HALF clk = ~clk;

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("run limit reached with %0d words outstanding", pending.size());
        $display("TEST FAILED");
        $finish;
    end

    // pin actions of one phase; returns the wait that follows, WAIT_NONE when done
    function automatic wait_kind_t phase_actions(logic sda_in);
        logic [PHASE_W-1:0] p;
        p = step_no;
        step_no = p + 1'b1;
        case (run_cmd)
            CMD_START: begin
                if (p == 0) begin sda_q = 1'b1; scl_q = 1'b1; return WAIT_LONG; end
                if (p == 1) begin sda_q = 1'b0; return WAIT_SHORT; end
                if (p == 2) begin scl_q = 1'b0; return WAIT_SHORT; end
            end
            CMD_STOP: begin
                if (p == 0) begin
                    oe_q = 1'b1; sda_q = 1'b0; scl_q = 1'b0;
                    return WAIT_SHORT;
                end
                if (p == 1) begin scl_q = 1'b1; return WAIT_SHORT; end
                if (p == 2) begin sda_q = 1'b1; return WAIT_SHORT; end
            end
            CMD_WRITE: begin
                if (p == 0) begin oe_q = 1'b1; bits_done = '0; return WAIT_SHORT; end
                if (p == 1) begin sda_q = shifter[7]; return WAIT_SHORT; end
                if (p == 2) begin scl_q = 1'b1; return WAIT_SHORT; end
                if (p == 3) begin scl_q = 1'b0; return WAIT_SHORT; end
                if (p == 4) begin
                    shifter = shifter << 1;
                    bits_done = bits_done + 1'b1;
                    if (bits_done < BITS_PER_BYTE) begin
                        // next bit goes out on the same tick
                        sda_q = shifter[7];
                        step_no = PHASE_W'(2);
                        return WAIT_SHORT;
                    end
                    sda_q = 1'b1;
                end
            end
            CMD_READ: begin
                if (p == 0) begin
                    scl_q = 1'b0; sda_q = 1'b1; oe_q = 1'b0;
                    bits_done = '0; shifter = '0;
                    return WAIT_SHORT;
                end
                if (p == 1) begin scl_q = 1'b1; return WAIT_SHORT; end
                if (p == 2) begin
                    shifter = {shifter[6:0], sda_in};
                    scl_q = 1'b0;
                    bits_done = bits_done + 1'b1;
                    if (bits_done < BITS_PER_BYTE) begin
                        step_no = PHASE_W'(1);
                        return WAIT_SHORT;
                    end
                    oe_q = 1'b1;
                    rd_q = shifter;
                end
            end
            CMD_CHECK: begin
                if (p == 0) begin sda_q = 1'b1; oe_q = 1'b0; return WAIT_LONG; end
                if (p == 1) begin scl_q = 1'b1; return WAIT_LONG; end
                if (p == 2) begin ack_q = ~sda_in; scl_q = 1'b0; return WAIT_SHORT; end
                oe_q = 1'b1;
                sda_q = 1'b1;
            end
            CMD_ACK: begin
                if (p == 0) begin oe_q = 1'b1; sda_q = 1'b0; return WAIT_SHORT; end
                if (p == 1) begin scl_q = 1'b1; return WAIT_SHORT; end
                if (p == 2) begin
                    scl_q = 1'b0; sda_q = 1'b1; oe_q = 1'b0;
                    return WAIT_SHORT;
                end
            end
            CMD_NACK: begin
                if (p == 0) begin
                    oe_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
                    return WAIT_SHORT;
                end
                if (p == 1) begin scl_q = 1'b0; return WAIT_SHORT; end
                if (p == 2) begin sda_q = 1'b1; return WAIT_SHORT; end
                oe_q = 1'b0;
            end
            default: ;
        endcase
        return WAIT_NONE;
    endfunction

    function automatic bit run_to_wait(logic sda_in);
        wait_kind_t        k;
        logic [TICK_W-1:0] len;
        k = phase_actions(sda_in);
        if (k == WAIT_NONE)
            return 1'b1;
        len = (k == WAIT_LONG) ? t_long : t_short;
        ticks_left = (len == 0) ? TICK_W'(1) : len;
        return 1'b0;
    endfunction

    function automatic line_state_t next_line_state(cmd_t op, logic [BYTE_W-1:0] wb,
                                                    logic sda_in);
        bit          ended;
        line_state_t r;
        ended = 1'b0;
        if (run_cmd == CMD_NONE) begin
            if (op != CMD_NONE) begin
                run_cmd = op;
                step_no = '0;
                if (op == CMD_WRITE)
                    shifter = wb;
                ended = run_to_wait(sda_in);
            end
        end
        else begin
            if (ticks_left != 0)
                ticks_left = ticks_left - 1'b1;
            if (ticks_left == 0)
                ended = run_to_wait(sda_in);
        end
        if (ended) begin
            run_cmd = CMD_NONE;
            step_no = '0;
            ticks_left = '0;
            cmds_done++;
        end
        r.scl  = scl_q;
        r.sda  = sda_q;
        r.oe   = oe_q;
        r.busy = (run_cmd != CMD_NONE);
        r.done = ended;
        r.rd   = rd_q;
        r.ack  = ack_q;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : result_monitor
        line_state_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending.size() == 0) begin
                $error("result word with nothing pending");
                errors++;
            end
            else begin
                want = pending.pop_front();
                check_field("scl_level", want.scl, rsp_if.scl_level);
                check_field("sda_drive", want.sda, rsp_if.sda_drive);
                check_field("sda_output_enable", want.oe, rsp_if.sda_output_enable);
                check_field("busy_res", want.busy, rsp_if.busy_res);
                check_field("done_res", want.done, rsp_if.done_res);
                check_field("read_data", want.rd, rsp_if.read_data);
                check_field("ack_seen", want.ack, rsp_if.ack_seen);
                checked++;
            end
        end
    end

    // result side: random back-pressure while gaps are on, plus one long hold-off on request
    initial begin : result_sink
        int hold;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (long_stall) begin
                rsp_if.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                long_stall = 1'b0;
            end
            hold = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
        end
    end

    task automatic send_tick(cmd_t op, logic [BYTE_W-1:0] wb, logic sda_in, bit typed,
                             line_state_t want);
        int          gap;
        line_state_t got;
        if (cfg_up) begin
            cfg_if.valid <= 1'b0;
            cfg_up = 1'b0;
        end
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            if (req_up) begin
                req_if.valid <= 1'b0;
                req_up = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.write_byte <= wb;
        req_if.sda_level  <= sda_in;
        req_up = 1'b1;
        do @(posedge clk); while (!req_if.ready);
        if (run_cmd != CMD_NONE || op != CMD_NONE)
            work_items++;
        ticks_sent++;
        got = next_line_state(op, wb, sda_in);
        pending.push_back(typed ? want : got);
    endtask

    task automatic drain_results();
        if (req_up) begin
            req_if.valid <= 1'b0;
            req_up = 1'b0;
        end
        while (pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_up = 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == REG_SHORT_TICKS)
            t_short = val;
        else if (idx == REG_LONG_TICKS)
            t_long = val;
    endtask

    // mostly whole transfers: start, address, ack check, data bytes, stop
    function automatic void plan_transfer();
        int n;
        if ($urandom_range(0, 4) == 0) begin
            bus_plan.push_back(cmd_t'($urandom_range(1, 7)));
            return;
        end
        n = $urandom_range(1, 3);
        bus_plan.push_back(CMD_START);
        bus_plan.push_back(CMD_WRITE);
        bus_plan.push_back(CMD_CHECK);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) begin
                bus_plan.push_back(CMD_WRITE);
                bus_plan.push_back(CMD_CHECK);
            end
            else begin
                bus_plan.push_back(CMD_READ);
                bus_plan.push_back((i == n - 1) ? CMD_NACK : CMD_ACK);
            end
        end
        bus_plan.push_back(CMD_STOP);
    endfunction

    task automatic random_tick();
        cmd_t op;
        if (run_cmd != CMD_NONE)
            op = ($urandom_range(0, 9) == 0) ? cmd_t'($urandom_range(1, 7)) : CMD_NONE;
        else if ($urandom_range(0, 3) == 0)
            op = CMD_NONE;
        else begin
            if (bus_plan.size() == 0)
                plan_transfer();
            op = bus_plan.pop_front();
        end
        send_tick(op, BYTE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0, NO_WANT);
    endtask

    initial begin : stimulus
        int target;
        int halfway;
        bit mid_done;
        req_if.valid      <= 1'b0;
        req_if.op         <= CMD_NONE;
        req_if.write_byte <= '0;
        req_if.sda_level  <= 1'b1;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= REG_SHORT_TICKS;
        cfg_if.data       <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++) begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_reg(DIRECTED[i].idx, DIRECTED[i].val);
            else
                do
                    send_tick(DIRECTED[i].op, DIRECTED[i].wb, DIRECTED[i].sda,
                              DIRECTED[i].typed, DIRECTED[i].want);
                while (DIRECTED[i].run_out && run_cmd != CMD_NONE);
        end

        for (int ph = 0; ph < $size(PHASES); ph++) begin
            while (run_cmd != CMD_NONE)
                random_tick();
            write_reg(REG_SHORT_TICKS, PHASES[ph].s_ticks);
            write_reg(REG_LONG_TICKS, PHASES[ph].l_ticks);
            gaps_on = PHASES[ph].gaps;
            target = work_items + RANDOM_ITEMS / $size(PHASES);
            halfway = work_items + RANDOM_ITEMS / (2 * $size(PHASES));
            mid_done = 1'b0;
            while (work_items < target || run_cmd != CMD_NONE) begin
                if (!mid_done && work_items >= halfway) begin
                    mid_done = 1'b1;
                    if (PHASES[ph].pause)
                        drain_results();
                    if (PHASES[ph].stall)
                        long_stall = 1'b1;
                end
                random_tick();
            end
        end

        // full-scale waits, no idling
        write_reg(REG_SHORT_TICKS, 16'hFFFF);
        write_reg(REG_LONG_TICKS, 16'hFFFF);
        gaps_on = 1'b0;
        for (int i = 0; i < FULL_SCALE_TICKS; i++)
            send_tick(CMD_START, BYTE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0, NO_WANT);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Drove %0d tick words, %0d of them starting or stepping a command,",
                 ticks_sent, work_items);
        $display("over reset, zero, small and full-scale waits; %0d commands, %0d words compared.",
                 cmds_done, checked);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ims_pkg.sv
rtl/ims_if.sv
rtl/ims_step.sv
rtl/i2c_master_bit_sequencer_top.sv
rtl/ims_checker.sv
tb/tb_i2c_master_bit_sequencer_top.sv
